[sv/ttacc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the triangle tangent accumulator.
// No dependencies; every other file refers to this package by scoped names.
package ttacc_pkg;

    localparam int VERTEX_DEPTH = 1024;
    localparam int IDX_W        = $clog2(VERTEX_DEPTH);
    localparam int DIV_STEPS    = 80;   // 64-bit magnitude plus 16 fraction bits
    localparam int CNT_W        = $clog2(DIV_STEPS);

    // sequencer count limits
    localparam logic [CNT_W-1:0] VRD_LAST = CNT_W'(3);   // three reads, one capture behind
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(8);   // eight products, one fold behind
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TRI   = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    localparam logic [1:0] ROLE_NONE = 2'd3;

    typedef struct packed {
        t_op                cmd;
        logic [9:0]         vertex_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic [9:0]         corner_a;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic [1:0]         corner_role;
        logic               degenerate;
        logic               saturated;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       latch;
        logic       vwrite;
        logic       vrd_en;
        logic [1:0] vrd_sel;
        logic       vcap_en;
        logic [1:0] vcap_sel;
        logic       delta_ld;
        logic       mul_go;
        logic [2:0] mul_sel;
        logic       div_init;
        logic       div_step;
        logic       div_fin;
        logic       acc_rd_en;
        logic       acc_use_idx;
        logic       acc_wr_en;
        logic       role_wr_en;
        logic [1:0] corner_sel;
        logic       out_ld;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic det_zero;
        logic out_free;
    } t_sts;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_WRITE = 13'b0000000000010,
        S_VRD   = 13'b0000000000100,
        S_DELTA = 13'b0000000001000,
        S_MUL   = 13'b0000000010000,
        S_DINIT = 13'b0000000100000,
        S_DIV   = 13'b0000001000000,
        S_DFIN  = 13'b0000010000000,
        S_ARD   = 13'b0000100000000,
        S_AWR   = 13'b0001000000000,
        S_READ  = 13'b0010000000000,
        S_FIN   = 13'b0100000000000,
        S_SPARE = 13'b1000000000000
    } t_state;

endpackage

[sv/ttacc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the tangent accumulator: one item at a time.
// Depends on ttacc_pkg; drives ttacc_dp through t_ctl, watches t_sts.
module ttacc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ttacc_pkg::t_op    i_in_op,
    input  ttacc_pkg::t_sts   i_sts,
    output logic              o_in_ready,
    output ttacc_pkg::t_ctl   o_ctl
);

    ttacc_pkg::t_state               r_state, n_state;
    logic [ttacc_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [1:0]                      r_corner, n_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ttacc_pkg::S_IDLE;
            r_cnt    <= '0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_corner <= n_corner;
        end
    end

    assign o_in_ready = (r_state == ttacc_pkg::S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_corner = r_corner;
        o_ctl    = '0;
        o_ctl.corner_sel = r_corner;
        case (r_state)
            ttacc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.latch = 1'b1;
                    n_cnt       = '0;
                    n_corner    = '0;
                    case (i_in_op)
                        ttacc_pkg::OP_WRITE: n_state = ttacc_pkg::S_WRITE;
                        ttacc_pkg::OP_TRI:   n_state = ttacc_pkg::S_VRD;
                        ttacc_pkg::OP_READ:  n_state = ttacc_pkg::S_READ;
                        default:             n_state = ttacc_pkg::S_FIN;
                    endcase
                end
            end
            ttacc_pkg::S_WRITE: begin
                o_ctl.vwrite = 1'b1;
                n_state      = ttacc_pkg::S_FIN;
            end
            ttacc_pkg::S_VRD: begin
                // read a, b, c back to back; each is captured in the cycle after its read
                o_ctl.vrd_en   = (r_cnt < ttacc_pkg::VRD_LAST);
                o_ctl.vrd_sel  = r_cnt[1:0];
                o_ctl.vcap_en  = (r_cnt != '0);
                o_ctl.vcap_sel = r_cnt[1:0] - 2'd1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == ttacc_pkg::VRD_LAST) begin
                    n_state = ttacc_pkg::S_DELTA;
                end
            end
            ttacc_pkg::S_DELTA: begin
                o_ctl.delta_ld = 1'b1;
                n_cnt          = '0;
                n_state        = ttacc_pkg::S_MUL;
            end
            ttacc_pkg::S_MUL: begin
                // eight products, the last one folds in during the cycle after it
                o_ctl.mul_go  = (r_cnt < ttacc_pkg::MUL_LAST);
                o_ctl.mul_sel = r_cnt[2:0];
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == ttacc_pkg::MUL_LAST) begin
                    n_state = ttacc_pkg::S_DINIT;
                end
            end
            ttacc_pkg::S_DINIT: begin
                o_ctl.div_init = 1'b1;
                n_cnt          = '0;
                n_corner       = '0;
                n_state        = i_sts.det_zero ? ttacc_pkg::S_ARD : ttacc_pkg::S_DIV;
            end
            ttacc_pkg::S_DIV: begin
                o_ctl.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == ttacc_pkg::DIV_LAST) begin
                    n_state = ttacc_pkg::S_DFIN;
                end
            end
            ttacc_pkg::S_DFIN: begin
                o_ctl.div_fin = 1'b1;
                n_state       = ttacc_pkg::S_ARD;
            end
            ttacc_pkg::S_ARD: begin
                o_ctl.acc_rd_en = 1'b1;
                n_state         = ttacc_pkg::S_AWR;
            end
            ttacc_pkg::S_AWR: begin
                o_ctl.role_wr_en = 1'b1;
                o_ctl.acc_wr_en  = !i_sts.det_zero;
                if (r_corner == 2'd2) begin
                    n_state = ttacc_pkg::S_FIN;
                end else begin
                    n_corner = r_corner + 2'd1;
                    n_state  = ttacc_pkg::S_ARD;
                end
            end
            ttacc_pkg::S_READ: begin
                o_ctl.acc_rd_en   = 1'b1;
                o_ctl.acc_use_idx = 1'b1;
                n_state           = ttacc_pkg::S_FIN;
            end
            ttacc_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.out_ld = 1'b1;
                    n_state      = ttacc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttacc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[sv/ttacc_dp.sv]
`timescale 1ns / 1ps
// Datapath: vertex, accumulator and role stores, delta stage, shared
// multiplier, three-lane restoring divider, output register. Uses ttacc_pkg.
module ttacc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ttacc_pkg::t_in_item  i_in_data,
    input  ttacc_pkg::t_ctl      i_ctl,
    output ttacc_pkg::t_sts      o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output ttacc_pkg::t_out_item o_out_data
);

    typedef logic [4:0][31:0] t_vtx;   // x, y, z, u, v
    typedef logic [2:0][31:0] t_tan;

    // {sat, value}: fold a 33-bit sum back into 32 bits
    function automatic logic [32:0] clamp33(input logic [32:0] v);
        if (v[32] != v[31]) begin
            return {1'b1, v[32], {31{!v[32]}}};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [ttacc_pkg::IDX_W-1:0] corner_addr(
        input ttacc_pkg::t_in_item it, input logic [1:0] sel);
        case (sel)
            2'd0:    return it.corner_a[ttacc_pkg::IDX_W-1:0];
            2'd1:    return it.corner_b[ttacc_pkg::IDX_W-1:0];
            default: return it.corner_c[ttacc_pkg::IDX_W-1:0];
        endcase
    endfunction

    ttacc_pkg::t_in_item r_item;
    t_vtx                m_vtx [ttacc_pkg::VERTEX_DEPTH];
    t_tan                m_acc [ttacc_pkg::VERTEX_DEPTH];
    logic [1:0]          m_role [ttacc_pkg::VERTEX_DEPTH];

    t_vtx                r_vrd;
    t_vtx                r_vtx [3];
    logic signed [31:0]  r_dba [5];
    logic signed [31:0]  r_dca [5];
    logic signed [63:0]  r_prod, r_sum;
    logic signed [63:0]  r_res [4];      // num x, y, z, det
    logic                r_mv;
    logic [2:0]          r_msel;
    logic [63:0]         r_dvs;
    logic [79:0]         r_dvd [3];
    logic [63:0]         r_rem [3];
    logic [32:0]         r_q [3];
    logic                r_over [3];
    logic                r_neg [3];
    logic signed [31:0]  r_t [3];
    t_tan                r_accrd;
    logic [1:0]          r_rolerd;
    logic                r_sat;
    logic                r_out_valid;
    ttacc_pkg::t_out_item r_out;

    logic [ttacc_pkg::IDX_W-1:0] w_idx, w_caddr, w_raddr;
    logic [32:0]         w_dba [5];
    logic [32:0]         w_dca [5];
    logic                w_dsat;
    logic signed [31:0]  w_ma, w_mb;
    logic [64:0]         w_rs [3];
    logic                w_ge [3];
    logic [64:0]         w_rn [3];
    logic [31:0]         w_qt [3];
    logic                w_qsat [3];
    t_tan                w_accsum;
    logic                w_asat;
    logic                w_det_zero;
    ttacc_pkg::t_out_item w_out;

    assign w_idx      = r_item.vertex_index[ttacc_pkg::IDX_W-1:0];
    assign w_caddr    = corner_addr(r_item, i_ctl.corner_sel);
    assign w_raddr    = i_ctl.acc_use_idx ? w_idx : w_caddr;
    assign w_det_zero = (r_res[3] == 64'sd0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_item <= i_in_data;
        end
    end

    // vertex store
    always_ff @(posedge i_clk) begin
        if (i_ctl.vwrite) begin
            m_vtx[w_idx] <= {r_item.tex_v, r_item.tex_u, r_item.pos_z,
                             r_item.pos_y, r_item.pos_x};
        end
        if (i_ctl.vrd_en) begin
            r_vrd <= m_vtx[corner_addr(r_item, i_ctl.vrd_sel)];
        end
        if (i_ctl.vcap_en) begin
            r_vtx[i_ctl.vcap_sel] <= r_vrd;
        end
    end

    // edge and uv deltas, saturated
    always_comb begin
        w_dsat = 1'b0;
        for (int j = 0; j < 5; j++) begin
            w_dba[j] = clamp33({r_vtx[1][j][31], r_vtx[1][j]} - {r_vtx[0][j][31], r_vtx[0][j]});
            w_dca[j] = clamp33({r_vtx[2][j][31], r_vtx[2][j]} - {r_vtx[0][j][31], r_vtx[0][j]});
            w_dsat   = w_dsat | w_dba[j][32] | w_dca[j][32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.delta_ld) begin
            for (int j = 0; j < 5; j++) begin
                r_dba[j] <= w_dba[j][31:0];
                r_dca[j] <= w_dca[j][31:0];
            end
        end
    end

    // shared multiplier: products in pairs, second of each pair subtracted
    // index 4 of a delta row is v, 3 is u
    always_comb begin
        case (i_ctl.mul_sel)
            3'd0:    begin w_ma = r_dca[4]; w_mb = r_dba[0]; end
            3'd1:    begin w_ma = r_dba[4]; w_mb = r_dca[0]; end
            3'd2:    begin w_ma = r_dca[4]; w_mb = r_dba[1]; end
            3'd3:    begin w_ma = r_dba[4]; w_mb = r_dca[1]; end
            3'd4:    begin w_ma = r_dca[4]; w_mb = r_dba[2]; end
            3'd5:    begin w_ma = r_dba[4]; w_mb = r_dca[2]; end
            3'd6:    begin w_ma = r_dba[3]; w_mb = r_dca[4]; end
            default: begin w_ma = r_dca[3]; w_mb = r_dba[4]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= i_ctl.mul_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_go) begin
            r_prod <= w_ma * w_mb;
            r_msel <= i_ctl.mul_sel;
        end
        if (r_mv) begin
            if (!r_msel[0]) begin
                r_sum <= r_prod;
            end else begin
                r_res[r_msel[2:1]] <= r_sum - r_prod;
            end
        end
    end

    // three divider lanes sharing one divisor, one quotient bit per cycle
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rs[k] = {r_rem[k], r_dvd[k][79]};
            w_ge[k] = (w_rs[k] >= {1'b0, r_dvs});
            w_rn[k] = w_ge[k] ? (w_rs[k] - {1'b0, r_dvs}) : w_rs[k];
            if (r_neg[k]) begin
                w_qsat[k] = r_over[k] || (r_q[k] > 33'h080000000);
                w_qt[k]   = w_qsat[k] ? 32'h80000000 : (32'd0 - r_q[k][31:0]);
            end else begin
                w_qsat[k] = r_over[k] || (r_q[k] > 33'h07FFFFFFF);
                w_qt[k]   = w_qsat[k] ? 32'h7FFFFFFF : r_q[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_init) begin
            r_dvs <= mag64(r_res[3]);
            for (int k = 0; k < 3; k++) begin
                r_dvd[k]  <= {mag64(r_res[k]), 16'd0};
                r_rem[k]  <= '0;
                r_q[k]    <= '0;
                r_over[k] <= 1'b0;
                r_neg[k]  <= r_res[k][63] ^ r_res[3][63];
                if (w_det_zero) begin
                    r_t[k] <= '0;
                end
            end
        end else if (i_ctl.div_step) begin
            for (int k = 0; k < 3; k++) begin
                r_dvd[k]  <= {r_dvd[k][78:0], 1'b0};
                r_rem[k]  <= w_rn[k][63:0];
                r_q[k]    <= {r_q[k][31:0], w_ge[k]};
                r_over[k] <= r_over[k] | r_q[k][32];
            end
        end else if (i_ctl.div_fin) begin
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= w_qt[k];
            end
        end
    end

    // accumulator update
    always_comb begin
        logic [32:0] s;
        w_asat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            s           = clamp33({r_accrd[k][31], r_accrd[k]} + {r_t[k][31], r_t[k]});
            w_accsum[k] = s[31:0];
            w_asat      = w_asat | s[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vwrite) begin
            m_acc[w_idx] <= '0;
        end else if (i_ctl.acc_wr_en) begin
            m_acc[w_caddr] <= w_accsum;
        end
        if (i_ctl.vwrite) begin
            m_role[w_idx] <= ttacc_pkg::ROLE_NONE;
        end else if (i_ctl.role_wr_en) begin
            m_role[w_caddr] <= i_ctl.corner_sel;
        end
        if (i_ctl.acc_rd_en) begin
            r_accrd  <= m_acc[w_raddr];
            r_rolerd <= m_role[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_sat <= 1'b0;
        end else begin
            r_sat <= r_sat
                   | (i_ctl.delta_ld & w_dsat)
                   | (i_ctl.div_fin & (w_qsat[0] | w_qsat[1] | w_qsat[2]))
                   | (i_ctl.acc_wr_en & w_asat);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        w_out = '0;
        case (r_item.cmd)
            ttacc_pkg::OP_TRI: begin
                w_out.tangent_x  = r_t[0];
                w_out.tangent_y  = r_t[1];
                w_out.tangent_z  = r_t[2];
                w_out.degenerate = w_det_zero;
                w_out.saturated  = r_sat;
            end
            ttacc_pkg::OP_READ: begin
                w_out.tangent_x   = r_accrd[0];
                w_out.tangent_y   = r_accrd[1];
                w_out.tangent_z   = r_accrd[2];
                w_out.corner_role = r_rolerd;
            end
            default: begin
                w_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_ld) begin
            r_out <= w_out;
        end
    end

    assign o_sts.det_zero = w_det_zero;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

[sv/triangle_tangent_accumulator_unit.sv]
`timescale 1ns / 1ps
// Top level of the per-triangle tangent accumulator.
// Depends on ttacc_pkg, ttacc_ctrl and ttacc_dp.
//
// Usage
//   Input channel (i_in_valid / o_in_ready, payload i_in_data) takes one item:
//   write vertex, process triangle, read vertex tangent, or no-op. Output
//   channel (o_out_valid / i_out_ready, payload o_out_data) returns exactly
//   one result item per input item, in order.
//   Items are handled one at a time. A triangle uses an 80-step restoring
//   divider whose three lanes share the determinant; a degenerate triangle
//   skips the divider and does not add into its accumulator slots.
//   Input is ready again the cycle after the result is loaded.
//   A triangle reads its three vertices one per cycle from a single port,
//   runs eight products through one 32x32 multiplier, divides, then does
//   three read-modify-write passes over the accumulator store.
//   Reset (synchronous, active low) clears the sequencer and the output
//   valid; the stores are not cleared, and every slot must be written
//   before a triangle or read uses it.
//   When the receiver stalls, the finished result waits in the output
//   register and the block still accepts one more item; that item is worked
//   on and its result held until the register frees up.
module triangle_tangent_accumulator_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ttacc_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ttacc_pkg::t_out_item o_out_data
);

    ttacc_pkg::t_ctl w_ctl;
    ttacc_pkg::t_sts w_sts;

    ttacc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.cmd),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_ctl      (w_ctl)
    );

    ttacc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[sv/ttacc_chk.sv]
`timescale 1ns / 1ps
// Port-level checks for the tangent accumulator, bound to the top level.
// Depends on ttacc_pkg and triangle_tangent_accumulator_unit.
module ttacc_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input ttacc_pkg::t_in_item  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input ttacc_pkg::t_out_item o_out_data
);

    // result holds while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted back to back");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.tangent_x == 32'sd0 && o_out_data.tangent_y == 32'sd0 &&
            o_out_data.tangent_z == 32'sd0 && o_out_data.corner_role == 2'd0)
        else $error("degenerate triangle with nonzero tangent");

    a_role_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.corner_role != 2'd0 |->
            !o_out_data.degenerate && !o_out_data.saturated)
        else $error("role reported with triangle flags");

endmodule

bind triangle_tangent_accumulator_unit ttacc_chk u_ttacc_chk (.*);
